@@ src/krt_pkg.sv @@
// shared types and codes of the keyed record table
package krt_pkg;

  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_UPDATE = 3'd1;
  localparam logic [2:0] OP_SEARCH = 3'd2;
  localparam logic [2:0] OP_REMOVE = 3'd3;
  localparam logic [2:0] OP_DUMP   = 3'd4;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_DUP      = 3'd1;
  localparam logic [2:0] ST_NOTFOUND = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [15:0]        item_id;
    logic [63:0]        item_name;
    logic signed [31:0] item_quantity;
    logic [31:0]        item_price;
  } in_word_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [15:0]        found_id;
    logic [63:0]        found_name;
    logic signed [31:0] found_quantity;
    logic [31:0]        found_price;
    logic [4:0]         free_slots;
    logic               last;
  } out_word_t;

  typedef struct packed {
    logic [15:0]        id;
    logic [63:0]        name;
    logic signed [31:0] quantity;
    logic [31:0]        price;
  } rec_t;

  typedef enum logic [1:0] {
    SEL_NONE,
    SEL_HIT,
    SEL_READ
  } sel_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_RESP,
    S_DUMP_RD,
    S_DUMP_OUT
  } state_t;

  typedef struct packed {
    logic       load_cmd;
    logic       walk_start;
    logic       scan_run;
    logic       shift_start;
    logic       shift_run;
    logic       dump_rd;
    logic       dump_next;
    logic       wr_insert;
    logic       wr_update;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       out_load;
    logic [2:0] out_status;
    sel_t       out_sel;
    logic       out_last;
  } ctl_t;

  typedef struct packed {
    logic [2:0] op;
    logic       hit;
    logic       miss;
    logic       found;
    logic       full;
    logic       empty;
    logic       shift_done;
    logic       dump_last;
    logic       out_free;
  } sts_t;

endpackage

@@ src/keyed_record_table.sv @@
// keyed record table top level: controller, datapath and checks
// A packed table of up to CAPACITY records (key, name tag, quantity, price)
// kept in one memory with a single read and a single write port and a
// registered read. One word is taken at a time. Insert, update, search and
// remove walk the stored records in order, one per cycle behind the
// registered read, and stop at the first matching key or after the last
// record; on an empty table they read no record. Remove then compacts the
// records above the hit at one per cycle. Dump emits one word per record,
// reading each record and then loading it into the result register, paced
// by the read port and held while that register is full, last flagged on
// the final one. The result register lets a finished word wait while the
// next word is accepted. The stores need no clearing pass after reset.
module keyed_record_table #(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  krt_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output krt_pkg::out_word_t out_word
);
  import krt_pkg::*;

  ctl_t ctl;
  sts_t sts;

  krt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_word.opcode),
    .in_stall  (in_stall),
    .sts       (sts),
    .ctl       (ctl)
  );

  krt_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .sts       (sts),
    .in_word   (in_word),
    .out_word  (out_word),
    .out_valid (out_valid),
    .out_stall (out_stall)
  );

  // a valid operation keeps the input side closed while it runs
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_word.opcode == OP_INSERT ||
     in_word.opcode == OP_UPDATE || in_word.opcode == OP_SEARCH ||
     in_word.opcode == OP_REMOVE || in_word.opcode == OP_DUMP))
    |=> in_stall)
    else $error("input accepted again while an operation runs");

  a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.out_load |-> sts.out_free)
    else $error("result register overwritten while stalled");

  a_insert_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.wr_insert |-> (!sts.full && !sts.found))
    else $error("insert written into a full table or over a duplicate");

  a_no_write_while_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !(ctl.wr_insert || ctl.wr_update || ctl.shift_run))
    else $error("memory written while idle");

endmodule

@@ src/krt_ctrl.sv @@
// sequencing state machine of the keyed record table
module krt_ctrl (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  input  logic [2:0]   in_opcode,
  output logic         in_stall,
  input  krt_pkg::sts_t sts,
  output krt_pkg::ctl_t ctl
);
  import krt_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_opcode)
            OP_INSERT, OP_UPDATE, OP_SEARCH, OP_REMOVE: state_nxt = S_SCAN;
            OP_DUMP: state_nxt = sts.empty ? S_RESP : S_DUMP_RD;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        if (sts.hit) begin
          state_nxt = (sts.op == OP_REMOVE) ? S_SHIFT : S_RESP;
        end else if (sts.miss) begin
          state_nxt = S_RESP;
        end
      end
      S_SHIFT: begin
        if (sts.shift_done) state_nxt = S_RESP;
      end
      S_RESP: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      S_DUMP_RD: state_nxt = S_DUMP_OUT;
      S_DUMP_OUT: begin
        if (sts.out_free) state_nxt = sts.dump_last ? S_IDLE : S_DUMP_RD;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    ctl.out_status = ST_OK;
    ctl.out_sel = SEL_NONE;
    in_stall = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          ctl.load_cmd = 1'b1;
          ctl.walk_start = 1'b1;
        end
      end
      S_SCAN: begin
        ctl.scan_run = 1'b1;
        // compaction starts from the slot after the hit
        if (sts.hit && sts.op == OP_REMOVE) ctl.shift_start = 1'b1;
      end
      S_SHIFT: begin
        ctl.shift_run = 1'b1;
        if (sts.shift_done) ctl.cnt_dec = 1'b1;
      end
      S_RESP: begin
        ctl.out_last = 1'b1;
        case (sts.op)
          OP_INSERT: begin
            if (sts.found) begin
              ctl.out_status = ST_DUP;
            end else if (sts.full) begin
              ctl.out_status = ST_FULL;
            end else begin
              ctl.out_status = ST_OK;
              ctl.wr_insert = sts.out_free;
              ctl.cnt_inc = sts.out_free;
            end
          end
          OP_UPDATE: begin
            ctl.out_status = sts.found ? ST_OK : ST_NOTFOUND;
            ctl.wr_update = sts.found && sts.out_free;
          end
          OP_SEARCH: begin
            ctl.out_status = sts.found ? ST_OK : ST_NOTFOUND;
            ctl.out_sel = sts.found ? SEL_HIT : SEL_NONE;
          end
          OP_REMOVE: ctl.out_status = sts.found ? ST_OK : ST_NOTFOUND;
          OP_DUMP: ctl.out_status = ST_EMPTY;
          default: ctl.out_status = ST_OK;
        endcase
        ctl.out_load = sts.out_free;
      end
      S_DUMP_RD: ctl.dump_rd = 1'b1;
      S_DUMP_OUT: begin
        ctl.out_status = ST_OK;
        ctl.out_sel = SEL_READ;
        ctl.out_last = sts.dump_last;
        ctl.out_load = sts.out_free;
        ctl.dump_next = sts.out_free;
      end
      default: in_stall = 1'b1;
    endcase
  end

endmodule

@@ src/krt_dpath.sv @@
// record memory, walk counter, key compare and result register
module krt_dpath #(
  parameter int CAPACITY = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  krt_pkg::ctl_t     ctl,
  output krt_pkg::sts_t     sts,
  input  krt_pkg::in_word_t in_word,
  output krt_pkg::out_word_t out_word,
  output logic              out_valid,
  input  logic              out_stall
);
  import krt_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  rec_t mem [CAPACITY];

  in_word_t  cmd_r;
  rec_t      rdata_r;
  rec_t      hit_rec_r;
  logic [AW-1:0] hit_idx_r;
  logic [AW-1:0] pend_idx_r, pend_idx_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic      pend_r, pend_nxt;
  logic      found_r;
  logic      out_valid_r;
  out_word_t out_word_r, out_word_nxt;

  logic      walk_live, idx_lt, rd_en, match, out_free;
  logic      wr_en;
  logic [AW-1:0] wr_addr;
  rec_t      wr_data, out_rec;
  logic [CW-1:0] free_full;

  assign walk_live = ctl.scan_run || ctl.shift_run;
  assign idx_lt    = idx_r < count_r;
  assign rd_en     = (walk_live && idx_lt) || ctl.dump_rd;
  assign match     = pend_r && (rdata_r.id == cmd_r.item_id);
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = hit_idx_r;
    wr_data = '{id: cmd_r.item_id, name: cmd_r.item_name,
                quantity: cmd_r.item_quantity, price: cmd_r.item_price};
    if (ctl.shift_run && pend_r) begin
      // move the word read last cycle down by one slot
      wr_en   = 1'b1;
      wr_addr = pend_idx_r - AW'(1);
      wr_data = rdata_r;
    end else if (ctl.wr_insert) begin
      wr_en   = 1'b1;
      wr_addr = count_r[AW-1:0];
    end else if (ctl.wr_update) begin
      wr_en   = 1'b1;
      wr_addr = hit_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rdata_r <= mem[idx_r[AW-1:0]];
  end

  always_comb begin
    idx_nxt      = idx_r;
    pend_nxt     = 1'b0;
    pend_idx_nxt = pend_idx_r;
    if (ctl.walk_start) begin
      idx_nxt = '0;
    end else if (ctl.shift_start) begin
      idx_nxt = CW'(pend_idx_r) + CW'(1);
    end else if (walk_live && idx_lt) begin
      idx_nxt      = idx_r + CW'(1);
      pend_nxt     = 1'b1;
      pend_idx_nxt = idx_r[AW-1:0];
    end else if (ctl.dump_next) begin
      idx_nxt = idx_r + CW'(1);
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (ctl.cnt_inc) count_nxt = count_r + CW'(1);
    else if (ctl.cnt_dec) count_nxt = count_r - CW'(1);
  end

  assign free_full = CW'(CAPACITY) - count_nxt;

  always_comb begin
    case (ctl.out_sel)
      SEL_HIT:  out_rec = hit_rec_r;
      SEL_READ: out_rec = rdata_r;
      default:  out_rec = '0;
    endcase
    out_word_nxt.status         = ctl.out_status;
    out_word_nxt.found_id       = out_rec.id;
    out_word_nxt.found_name     = out_rec.name;
    out_word_nxt.found_quantity = out_rec.quantity;
    out_word_nxt.found_price    = out_rec.price;
    out_word_nxt.free_slots     = 5'(free_full);
    out_word_nxt.last           = ctl.out_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      pend_idx_r  <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r    <= count_nxt;
      idx_r      <= idx_nxt;
      pend_r     <= pend_nxt;
      pend_idx_r <= pend_idx_nxt;
      if (ctl.walk_start) found_r <= 1'b0;
      else if (ctl.scan_run && match) found_r <= 1'b1;
      if (ctl.out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_cmd) cmd_r <= in_word;
    if (ctl.scan_run && match) begin
      hit_idx_r <= pend_idx_r;
      hit_rec_r <= rdata_r;
    end
    if (ctl.out_load) out_word_r <= out_word_nxt;
  end

  assign sts.op         = cmd_r.opcode;
  assign sts.hit        = match;
  assign sts.miss       = !pend_r && !idx_lt;
  assign sts.found      = found_r;
  assign sts.full       = count_r == CW'(CAPACITY);
  assign sts.empty      = count_r == '0;
  assign sts.shift_done = !pend_r && !idx_lt;
  assign sts.dump_last  = (idx_r + CW'(1)) == count_r;
  assign sts.out_free   = out_free;

  assign out_word  = out_word_r;
  assign out_valid = out_valid_r;

endmodule

@@ tb/keyed_record_table_tb.sv @@
// self-checking testbench of the keyed record table: directed and random command traffic
module keyed_record_table_tb;
  import krt_pkg::*;

  localparam int CAP            = 16;
  localparam int KEY_POOL       = 20;
  localparam int RANDOM_ITEMS   = 264;
  localparam int DRAIN_CYCLES   = 80;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 400;

  // opcodes the block has to ignore
  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_word_t  in_word   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  // table contents as the block should hold them
  rec_t        model_records [CAP];
  int          record_count = 0;
  out_word_t   pending_results [$];
  logic [15:0] key_pool [KEY_POOL];

  int mismatches    = 0;
  int hold_request  = 0;
  bit no_gaps       = 1'b0;

  keyed_record_table #(.CAPACITY(CAP)) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic in_word_t make_word(logic [2:0] op, logic [15:0] id, logic [63:0] name,
                                         logic signed [31:0] qty, logic [31:0] price);
    in_word_t w;
    w.opcode        = op;
    w.item_id       = id;
    w.item_name     = name;
    w.item_quantity = qty;
    w.item_price    = price;
    return w;
  endfunction

  function automatic out_word_t record_word(rec_t rec);
    out_word_t r;
    r                = '0;
    r.status         = ST_OK;
    r.found_id       = rec.id;
    r.found_name     = rec.name;
    r.found_quantity = rec.quantity;
    r.found_price    = rec.price;
    return r;
  endfunction

  // works out the result words of one accepted command and updates the table
  function automatic void apply_command(in_word_t w);
    out_word_t r;
    int hit;
    hit = -1;
    for (int i = 0; i < record_count; i++)
      if (hit < 0 && model_records[i].id == w.item_id) hit = i;
    r = '0;
    r.last = 1'b1;
    case (w.opcode)
      OP_INSERT: begin
        if (hit >= 0) begin
          r.status = ST_DUP;
        end else if (record_count >= CAP) begin
          r.status = ST_FULL;
        end else begin
          model_records[record_count] = '{w.item_id, w.item_name, w.item_quantity, w.item_price};
          record_count++;
          r.status = ST_OK;
        end
      end
      OP_UPDATE: begin
        if (hit < 0) begin
          r.status = ST_NOTFOUND;
        end else begin
          model_records[hit].name     = w.item_name;
          model_records[hit].quantity = w.item_quantity;
          model_records[hit].price    = w.item_price;
          r.status = ST_OK;
        end
      end
      OP_SEARCH: begin
        if (hit < 0) begin
          r.status = ST_NOTFOUND;
        end else begin
          r = record_word(model_records[hit]);
          r.last = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (hit < 0) begin
          r.status = ST_NOTFOUND;
        end else begin
          // later records move down one slot, order kept
          for (int i = hit; i < record_count - 1; i++)
            model_records[i] = model_records[i + 1];
          record_count--;
          r.status = ST_OK;
        end
      end
      OP_DUMP: begin
        if (record_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          for (int i = 0; i < record_count; i++) begin
            r = record_word(model_records[i]);
            r.free_slots = 5'(CAP - record_count);
            r.last = (i == record_count - 1);
            pending_results.push_back(r);
          end
          return;
        end
      end
      default: return;
    endcase
    r.free_slots = 5'(CAP - record_count);
    pending_results.push_back(r);
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got_v, logic [63:0] want_v);
    mismatches++;
    if (mismatches <= 40)
      $display("%0t: %s mismatch, got %h, expected %h", $time, field, got_v, want_v);
  endtask

  task automatic check_word(out_word_t got);
    out_word_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("word with nothing expected, status", 64'(got.status), '0);
    end else begin
      want = pending_results.pop_front();
      if (got.status !== want.status)
        report_mismatch("status", 64'(got.status), 64'(want.status));
      if (got.found_id !== want.found_id)
        report_mismatch("found_id", 64'(got.found_id), 64'(want.found_id));
      if (got.found_name !== want.found_name)
        report_mismatch("found_name", got.found_name, want.found_name);
      if (got.found_quantity !== want.found_quantity)
        report_mismatch("found_quantity", 64'(got.found_quantity), 64'(want.found_quantity));
      if (got.found_price !== want.found_price)
        report_mismatch("found_price", 64'(got.found_price), 64'(want.found_price));
      if (got.free_slots !== want.free_slots)
        report_mismatch("free_slots", 64'(got.free_slots), 64'(want.free_slots));
      if (got.last !== want.last)
        report_mismatch("last", 64'(got.last), 64'(want.last));
    end
  endtask

  // both handshakes are sampled on the values before the edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_stall === 1'b0) apply_command(in_word);
      if (out_valid === 1'b1 && out_stall === 1'b0) check_word(out_word);
    end
  end

  task automatic send_word(in_word_t w);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
  endtask

  initial begin : receiver
    int n;
    @(posedge clk);
    forever begin
      if (hold_request > 0) begin
        n = hold_request;
        hold_request = 0;
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end else begin
        n = no_gaps ? 0 : pick_gap();
        out_stall <= (n > 0);
        repeat ((n > 0) ? n : 1) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0))
        idle = 0;
      else
        idle++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic test_directed_ops();
    send_word(make_word(OP_DUMP, 16'h0000, '0, '0, '0));           // empty table
    send_word(make_word(OP_SEARCH, 16'h1234, '0, '0, '0));
    send_word(make_word(OP_UPDATE, 16'h1234, 64'hDEAD_BEEF_0000_0001, 32'sd5, 32'd7));
    send_word(make_word(OP_REMOVE, 16'h1234, '0, '0, '0));
    send_word(make_word(OP_INSERT, 16'h0000, '1, 32'sh8000_0000, 32'hFFFF_FFFF));
    send_word(make_word(OP_INSERT, 16'hFFFF, '0, 32'sh7FFF_FFFF, 32'h0000_0000));
    send_word(make_word(OP_INSERT, 16'h0000, 64'h1111, 32'sd1, 32'd1));  // duplicate key
    send_word(make_word(OP_SEARCH, 16'h0000, '0, '0, '0));
    send_word(make_word(OP_SEARCH, 16'hFFFF, '0, '0, '0));
    send_word(make_word(OP_UPDATE, 16'hFFFF, 64'h0123_4567_89AB_CDEF, -32'sd1, 32'd1));
    send_word(make_word(OP_SEARCH, 16'hFFFF, '0, '0, '0));
    for (int op = OP_UNUSED_LO; op <= OP_UNUSED_HI; op++)
      send_word(make_word(3'(op), 16'h0000, '1, '1, '1));
    send_word(make_word(OP_DUMP, 16'h0000, '0, '0, '0));
    send_word(make_word(OP_REMOVE, 16'h0000, '0, '0, '0));          // first record, shift down
    send_word(make_word(OP_DUMP, 16'h0000, '0, '0, '0));
  endtask

  task automatic test_table_full();
    // one record is left over, so the last inserts hit a full table
    for (int i = 0; i < 17; i++)
      send_word(make_word(OP_INSERT, 16'(16'h1000 + i), {$urandom(), $urandom()}, $urandom(),
                          $urandom()));
    send_word(make_word(OP_INSERT, 16'h1000, '0, '0, '0));          // duplicate beats full
    send_word(make_word(OP_DUMP, 16'h0000, '0, '0, '0));
    send_word(make_word(OP_REMOVE, 16'h1007, '0, '0, '0));
    send_word(make_word(OP_REMOVE, 16'hFFFF, '0, '0, '0));
    send_word(make_word(OP_REMOVE, 16'h100E, '0, '0, '0));
    send_word(make_word(OP_DUMP, 16'h0000, '0, '0, '0));
  endtask

  task automatic test_backpressure();
    no_gaps = 1'b1;
    hold_request = HOLD_CYCLES;
    for (int i = 0; i < 14; i++)
      send_word(make_word((i % 2) ? OP_SEARCH : OP_DUMP, 16'(16'h1000 + i), '0, '0, '0));
    no_gaps = 1'b0;
  endtask

  function automatic in_word_t random_command(int insert_pct);
    in_word_t w;
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) w.item_id = 16'($urandom_range(0, 16'hFFFF));
    else w.item_id = key_pool[$urandom_range(0, KEY_POOL - 1)];
    w.item_name = {$urandom(), $urandom()};
    r = $urandom_range(0, 99);
    w.item_quantity = (r < 5) ? 32'h8000_0000 : (r < 10) ? 32'h7FFF_FFFF : $urandom();
    r = $urandom_range(0, 99);
    w.item_price = (r < 5) ? 32'h0 : (r < 10) ? 32'hFFFF_FFFF : $urandom();
    r = $urandom_range(0, 99);
    if (r < insert_pct) begin
      w.opcode = OP_INSERT;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 25) w.opcode = OP_UPDATE;
      else if (r < 50) w.opcode = OP_SEARCH;
      else if (r < 78) w.opcode = OP_REMOVE;
      else if (r < 94) w.opcode = OP_DUMP;
      else w.opcode = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    end
    return w;
  endfunction

  task automatic test_random_traffic();
    in_word_t w;
    int sent;
    // fill phases alternate with drain phases on the same keys
    for (int phase = 0; phase < 4; phase++) begin
      if (phase % 2 == 0)
        for (int k = 0; k < KEY_POOL; k++) key_pool[k] = 16'($urandom_range(0, 16'hFFFF));
      no_gaps = (phase == 1);
      sent = 0;
      while (sent < RANDOM_ITEMS / 4) begin
        w = random_command((phase % 2 == 0) ? 60 : 20);
        send_word(w);
        if (w.opcode <= OP_DUMP) sent++;
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_ops();
    test_table_full();
    test_backpressure();
    test_random_traffic();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/krt_pkg.sv
src/krt_ctrl.sv
src/krt_dpath.sv
src/keyed_record_table.sv
tb/keyed_record_table_tb.sv
